[sv/traffic_matrix_block_reducer_macros.svh]
// Assertion macros shared by the traffic matrix block reducer modules.
`ifndef TRAFFIC_MATRIX_BLOCK_REDUCER_MACROS_SVH
`define TRAFFIC_MATRIX_BLOCK_REDUCER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clock and disabled in reset.
`define TMBR_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock and disabled in reset.
`define TMBR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TMBR_ASSERT_IMP(name, ante, cons, msg)
`define TMBR_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[sv/tmbr_pkg.sv]
// Shared types and constants of the traffic matrix block reducer.
`timescale 1ns / 1ps
package tmbr_pkg;

   localparam int FLOW_W    = 32;
   localparam int ACC_W     = 48;
   localparam int MAX_W     = 47;
   localparam int VTX_OUT_W = 4;
   localparam int VCNT_W    = 5;
   localparam int EPR_W     = 3;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;

   // Register indexes, taken from paddr[2].
   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic REG_EPR          = 1'b1;

   localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd16;
   localparam logic [EPR_W-1:0]  EPR_RESET  = 3'd4;

   typedef logic signed [FLOW_W-1:0] flow_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [MAX_W-1:0]         max_type;
   typedef logic [VTX_OUT_W-1:0]     vtx_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic acc;
      logic row_end;
      logic row_adv;
      logic k_clr;
      logic k_inc;
      logic blk_rd;
      logic load_blk;
      logic col_rd;
      logic col_cmp;
      logic load_sum;
      logic clear_run;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic col_last;
      logic vertex_last;
      logic row_last;
      logic k_last_v;
      logic k_last_col;
      logic rsp_taken;
   } status_type;

endpackage

[sv/tmbr_stream_if.sv]
// Request and response channel interfaces of the traffic matrix block reducer.
`timescale 1ns / 1ps
interface tmbr_req_if;
   logic               valid;
   logic               ready;
   tmbr_pkg::flow_type flow;

   modport source (output valid, output flow, input ready);
   modport sink (input valid, input flow, output ready);
endinterface

interface tmbr_rsp_if;
   logic               valid;
   logic               ready;
   tmbr_pkg::vtx_type  src_vertex;
   tmbr_pkg::vtx_type  dst_vertex;
   tmbr_pkg::acc_type  block_flow;
   logic               is_summary;
   tmbr_pkg::max_type  max_endpoint_flow;
   tmbr_pkg::acc_type  total_flow;
   logic               last;

   modport source (output valid, output src_vertex, output dst_vertex, output block_flow,
                   output is_summary, output max_endpoint_flow, output total_flow,
                   output last, input ready);
   modport sink (input valid, input src_vertex, input dst_vertex, input block_flow,
                 input is_summary, input max_endpoint_flow, input total_flow,
                 input last, output ready);
endinterface

[sv/traffic_matrix_block_reducer.sv]
// Top level of the traffic matrix block reducer.
`timescale 1ns / 1ps
// The block takes the elements of a square endpoint-to-endpoint flow matrix in
// row-major order, one signed Q16.16 element per request, with a side of
// vertex_count * endpoints_per_vertex (zero counts act as one, counts beyond
// MAX_VERTICES or MAX_EPR act as those limits). It sums every element into its
// column sum, its row sum, a run total and the block sum of its source and
// destination vertex, leaving out elements whose row and column belong to the
// same vertex. After the last endpoint row of a vertex it returns that vertex's
// block row, one response per destination vertex, with zero on the diagonal.
// After the final element it returns a summary response with the largest row
// or column sum (never below zero), the total and last set, and then starts a
// fresh run. Sums are 48-bit two's complement and wrap. Columns past
// MAX_ENDPOINTS are left out of the column sums. Writing either register
// abandons the current run. One request is handled at a time: each element is
// accepted, then given a read-modify-write of the column and block sum RAMs,
// whose read data is registered, and the last element of a row then passes a
// row-end step that folds the row sum into the maximum. Each block row response
// is read from the block sum RAM and held in the result register until taken;
// the summary is loaded after a scan that reads and compares each stored column,
// min(side, MAX_ENDPOINTS) of them. The RAMs need no clearing pass after reset:
// their contents are first written in the opening row of each run or vertex and
// stale values are never read.
module traffic_matrix_block_reducer #(
   parameter int MAX_VERTICES  = 16,
   parameter int MAX_EPR       = 4,
   parameter int MAX_ENDPOINTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   tmbr_req_if.sink                    req_chan,
   tmbr_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tmbr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tmbr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tmbr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   localparam int V_LIM    = (MAX_VERTICES < 31) ? MAX_VERTICES : 31;
   localparam int E_LIM    = (MAX_EPR < 7) ? MAX_EPR : 7;
   localparam int SIDE_LIM = V_LIM * E_LIM;
   localparam int IDX_W    = $clog2(SIDE_LIM + 1);
   localparam int VTX_W    = $clog2(V_LIM + 1);
   localparam int EPR_CW   = $clog2(E_LIM + 1);

   // Effective configuration, already clamped to the supported range.
   logic                 cfg_wr;
   logic [VTX_W-1:0]     eff_v;
   logic [EPR_CW-1:0]    eff_e;
   logic [IDX_W-1:0]     side;

   // Controller to datapath handshake.
   tmbr_pkg::cmd_type    cmd;
   tmbr_pkg::status_type status;

   tmbr_csr #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EPR      (MAX_EPR)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_wr      (cfg_wr),
      .eff_v       (eff_v),
      .eff_e       (eff_e),
      .side        (side)
   );

   // The controller only takes a new request when it is idle; every other
   // state belongs to the element or the result sequence in progress.
   tmbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the run counters, both sum RAMs and the result
   // register, which holds a response until the consumer takes it.
   tmbr_dpath #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_EPR       (MAX_EPR),
      .MAX_ENDPOINTS (MAX_ENDPOINTS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .cfg_wr                (cfg_wr),
      .eff_v                 (eff_v),
      .eff_e                 (eff_e),
      .side                  (side),
      .req_flow              (req_chan.flow),
      .rsp_ready             (rsp_chan.ready),
      .rsp_valid             (rsp_chan.valid),
      .rsp_src_vertex        (rsp_chan.src_vertex),
      .rsp_dst_vertex        (rsp_chan.dst_vertex),
      .rsp_block_flow        (rsp_chan.block_flow),
      .rsp_is_summary        (rsp_chan.is_summary),
      .rsp_max_endpoint_flow (rsp_chan.max_endpoint_flow),
      .rsp_total_flow        (rsp_chan.total_flow),
      .rsp_last              (rsp_chan.last)
   );
endmodule

[sv/tmbr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tmbr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/tmbr_csr.sv]
// Configuration registers of the reducer and their effective, clamped values.
`timescale 1ns / 1ps
module tmbr_csr #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EPR      = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tmbr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tmbr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tmbr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output logic                        cfg_wr,
   output logic [VTX_W-1:0]            eff_v,
   output logic [EPR_CW-1:0]           eff_e,
   output logic [IDX_W-1:0]            side
);
   localparam int V_LIM    = (MAX_VERTICES < 31) ? MAX_VERTICES : 31;
   localparam int E_LIM    = (MAX_EPR < 7) ? MAX_EPR : 7;
   localparam int SIDE_LIM = V_LIM * E_LIM;
   localparam int IDX_W    = $clog2(SIDE_LIM + 1);
   localparam int VTX_W    = $clog2(V_LIM + 1);
   localparam int EPR_CW   = $clog2(E_LIM + 1);
   localparam int PROD_W   = tmbr_pkg::VCNT_W + tmbr_pkg::EPR_W;

   localparam logic [tmbr_pkg::VCNT_W-1:0] V_LIM_C = tmbr_pkg::VCNT_W'(V_LIM);
   localparam logic [tmbr_pkg::EPR_W-1:0]  E_LIM_C = tmbr_pkg::EPR_W'(E_LIM);

   logic [tmbr_pkg::VCNT_W-1:0] vcount_ff, vcount_in;
   logic [tmbr_pkg::EPR_W-1:0]  epr_ff, epr_in;
   logic [tmbr_pkg::VCNT_W-1:0] v_clamp;
   logic [tmbr_pkg::EPR_W-1:0]  e_clamp;
   logic [PROD_W-1:0]           prod;
   logic                        reg_idx;

   assign reg_idx    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      vcount_in = vcount_ff;
      epr_in    = epr_ff;
      if (cfg_wr) begin
         case (reg_idx)
            tmbr_pkg::REG_VERTEX_COUNT: vcount_in = csr_pwdata[tmbr_pkg::VCNT_W-1:0];
            tmbr_pkg::REG_EPR:          epr_in    = csr_pwdata[tmbr_pkg::EPR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tmbr_pkg::REG_VERTEX_COUNT: csr_prdata = tmbr_pkg::CSR_DW'(vcount_ff);
         tmbr_pkg::REG_EPR:          csr_prdata = tmbr_pkg::CSR_DW'(epr_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= tmbr_pkg::VCNT_RESET;
         epr_ff    <= tmbr_pkg::EPR_RESET;
      end else begin
         vcount_ff <= vcount_in;
         epr_ff    <= epr_in;
      end
   end

   // A zero count behaves as one; a count beyond the storage behaves as its limit.
   always_comb begin
      if (vcount_ff == '0) begin
         v_clamp = tmbr_pkg::VCNT_W'(1);
      end else if (vcount_ff > V_LIM_C) begin
         v_clamp = V_LIM_C;
      end else begin
         v_clamp = vcount_ff;
      end
      if (epr_ff == '0) begin
         e_clamp = tmbr_pkg::EPR_W'(1);
      end else if (epr_ff > E_LIM_C) begin
         e_clamp = E_LIM_C;
      end else begin
         e_clamp = epr_ff;
      end
   end

   assign prod  = PROD_W'(v_clamp) * PROD_W'(e_clamp);
   assign eff_v = VTX_W'(v_clamp);
   assign eff_e = EPR_CW'(e_clamp);
   assign side  = IDX_W'(prod);
endmodule

[sv/tmbr_ctrl.sv]
// Sequencing state machine of the reducer: issues datapath commands per request.
`timescale 1ns / 1ps
`include "traffic_matrix_block_reducer_macros.svh"
module tmbr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tmbr_pkg::status_type status,
   output tmbr_pkg::cmd_type    cmd
);
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ACC      = 4'd1;
   localparam logic [3:0] S_ROWEND   = 4'd2;
   localparam logic [3:0] S_BLK_RD   = 4'd3;
   localparam logic [3:0] S_BLK_LD   = 4'd4;
   localparam logic [3:0] S_BLK_WAIT = 4'd5;
   localparam logic [3:0] S_COL_RD   = 4'd6;
   localparam logic [3:0] S_COL_CMP  = 4'd7;
   localparam logic [3:0] S_SUM_LD   = 4'd8;
   localparam logic [3:0] S_SUM_WAIT = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.col_last ? S_ROWEND : S_IDLE;
         end
         S_ROWEND: begin
            cmd.row_end = 1'b1;
            cmd.k_clr   = 1'b1;
            if (status.vertex_last) begin
               state_in = S_BLK_RD;
            end else begin
               cmd.row_adv = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_BLK_RD: begin
            cmd.blk_rd = 1'b1;
            state_in   = S_BLK_LD;
         end
         S_BLK_LD: begin
            cmd.load_blk = 1'b1;
            state_in     = S_BLK_WAIT;
         end
         S_BLK_WAIT: begin
            if (status.rsp_taken) begin
               if (!status.k_last_v) begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_BLK_RD;
               end else if (status.row_last) begin
                  cmd.k_clr = 1'b1;
                  state_in  = S_COL_RD;
               end else begin
                  cmd.row_adv = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_COL_RD: begin
            cmd.col_rd = 1'b1;
            state_in   = S_COL_CMP;
         end
         S_COL_CMP: begin
            cmd.col_cmp = 1'b1;
            if (status.k_last_col) begin
               state_in = S_SUM_LD;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_COL_RD;
            end
         end
         S_SUM_LD: begin
            cmd.load_sum = 1'b1;
            state_in     = S_SUM_WAIT;
         end
         S_SUM_WAIT: begin
            if (status.rsp_taken) begin
               cmd.clear_run = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TMBR_ASSERT_IMP(a_acc_after_accept, state_ff == S_ACC, $past(req_valid && req_ready), "accumulate step without an accepted request")
   `TMBR_ASSERT_IMP(a_rowend_after_acc, state_ff == S_ROWEND, $past(state_ff == S_ACC), "row end not preceded by an accumulate step")
endmodule

[sv/tmbr_dpath.sv]
// Datapath of the reducer: index counters, sum RAMs, accumulators and result register.
`timescale 1ns / 1ps
`include "traffic_matrix_block_reducer_macros.svh"
module tmbr_dpath #(
   parameter int MAX_VERTICES  = 16,
   parameter int MAX_EPR       = 4,
   parameter int MAX_ENDPOINTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmbr_pkg::cmd_type    cmd,
   output tmbr_pkg::status_type status,
   input  logic                 cfg_wr,
   input  logic [VTX_W-1:0]     eff_v,
   input  logic [EPR_CW-1:0]    eff_e,
   input  logic [IDX_W-1:0]     side,
   input  tmbr_pkg::flow_type   req_flow,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output tmbr_pkg::vtx_type    rsp_src_vertex,
   output tmbr_pkg::vtx_type    rsp_dst_vertex,
   output tmbr_pkg::acc_type    rsp_block_flow,
   output logic                 rsp_is_summary,
   output tmbr_pkg::max_type    rsp_max_endpoint_flow,
   output tmbr_pkg::acc_type    rsp_total_flow,
   output logic                 rsp_last
);
   localparam int V_LIM     = (MAX_VERTICES < 31) ? MAX_VERTICES : 31;
   localparam int E_LIM     = (MAX_EPR < 7) ? MAX_EPR : 7;
   localparam int SIDE_LIM  = V_LIM * E_LIM;
   localparam int IDX_W     = $clog2(SIDE_LIM + 1);
   localparam int VTX_W     = $clog2(V_LIM + 1);
   localparam int EPR_CW    = $clog2(E_LIM + 1);
   localparam int COL_DEPTH = (MAX_ENDPOINTS < SIDE_LIM) ? MAX_ENDPOINTS : SIDE_LIM;
   localparam int COL_AW    = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
   localparam int BLK_AW    = (V_LIM > 1) ? $clog2(V_LIM) : 1;
   localparam int ACC_W     = tmbr_pkg::ACC_W;
   localparam int MAX_W     = tmbr_pkg::MAX_W;
   localparam int EXT_W     = tmbr_pkg::ACC_W - tmbr_pkg::FLOW_W;

   // Run counters and accumulators.
   tmbr_pkg::acc_type   flow_ff, flow_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [IDX_W-1:0]    col_ff, col_in;
   logic [EPR_CW-1:0]   row_sub_ff, row_sub_in;
   logic [EPR_CW-1:0]   col_sub_ff, col_sub_in;
   logic [VTX_W-1:0]    src_ff, src_in;
   logic [VTX_W-1:0]    dst_ff, dst_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   tmbr_pkg::acc_type   row_acc_ff, row_acc_in;
   tmbr_pkg::acc_type   total_ff, total_in;
   tmbr_pkg::max_type   max_ff, max_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   tmbr_pkg::vtx_type   src_out_ff, src_out_in;
   tmbr_pkg::vtx_type   dst_out_ff, dst_out_in;
   tmbr_pkg::acc_type   blk_out_ff, blk_out_in;
   logic                is_summary_ff, is_summary_in;
   tmbr_pkg::max_type   max_out_ff, max_out_in;
   tmbr_pkg::acc_type   total_out_ff, total_out_in;
   logic                last_ff, last_in;

   // RAM ports.
   logic                col_we, blk_we;
   logic [COL_AW-1:0]   col_raddr;
   logic [BLK_AW-1:0]   blk_raddr;
   logic [ACC_W-1:0]    col_rdata, blk_rdata;
   tmbr_pkg::acc_type   col_new, blk_new;
   tmbr_pkg::acc_type   col_base, blk_base;

   logic                in_col_store;
   logic                col_sub_last, row_sub_last;
   logic [IDX_W-1:0]    scan_len, scan_last;
   tmbr_pkg::acc_type   max_cand;
   logic                max_take;
   logic                run_clr;

   assign run_clr      = cmd.clear_run || cfg_wr;
   assign in_col_store = (col_ff < IDX_W'(COL_DEPTH));
   assign col_sub_last = (col_sub_ff == eff_e - EPR_CW'(1));
   assign row_sub_last = (row_sub_ff == eff_e - EPR_CW'(1));
   assign scan_len     = (side < IDX_W'(COL_DEPTH)) ? side : IDX_W'(COL_DEPTH);
   assign scan_last    = scan_len - IDX_W'(1);

   // Column sums are first written in row zero of a run, so their stale contents
   // are never seen; block sums likewise in the first column of each block of the
   // first row of a vertex. No clearing pass is needed.
   assign col_base = (row_ff == '0) ? '0 : $signed(col_rdata);
   assign blk_base = (row_sub_ff == '0 && col_sub_ff == '0) ? '0 : $signed(blk_rdata);
   assign col_new  = col_base + flow_ff;
   assign blk_new  = blk_base + flow_ff;
   assign col_we   = cmd.acc && in_col_store;
   assign blk_we   = cmd.acc && (src_ff != dst_ff);

   assign col_raddr = cmd.col_rd ? COL_AW'(k_ff) : COL_AW'(col_ff);
   assign blk_raddr = cmd.blk_rd ? BLK_AW'(k_ff) : BLK_AW'(dst_ff);

   tmbr_ram #(.WIDTH(ACC_W), .DEPTH(COL_DEPTH)) u_col_ram (
      .clock (clock),
      .we    (col_we),
      .waddr (COL_AW'(col_ff)),
      .wdata (col_new),
      .raddr (col_raddr),
      .rdata (col_rdata)
   );

   tmbr_ram #(.WIDTH(ACC_W), .DEPTH(V_LIM)) u_blk_ram (
      .clock (clock),
      .we    (blk_we),
      .waddr (BLK_AW'(dst_ff)),
      .wdata (blk_new),
      .raddr (blk_raddr),
      .rdata (blk_rdata)
   );

   // A sum raises the maximum only when it is positive and above it.
   assign max_cand = cmd.col_cmp ? $signed(col_rdata) : row_acc_ff;
   assign max_take = !max_cand[ACC_W-1] && (max_cand[MAX_W-1:0] > max_ff);

   always_comb begin
      flow_in    = flow_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      row_sub_in = row_sub_ff;
      col_sub_in = col_sub_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      k_in       = k_ff;
      row_acc_in = row_acc_ff;
      total_in   = total_ff;
      max_in     = max_ff;

      if (cmd.capture) begin
         flow_in = {{EXT_W{req_flow[tmbr_pkg::FLOW_W-1]}}, req_flow};
      end

      if (cmd.acc) begin
         row_acc_in = row_acc_ff + flow_ff;
         total_in   = total_ff + flow_ff;
         if (status.col_last) begin
            col_in     = '0;
            col_sub_in = '0;
            dst_in     = '0;
         end else begin
            col_in = col_ff + IDX_W'(1);
            if (col_sub_last) begin
               col_sub_in = '0;
               dst_in     = dst_ff + VTX_W'(1);
            end else begin
               col_sub_in = col_sub_ff + EPR_CW'(1);
            end
         end
      end

      if (cmd.row_end) begin
         row_acc_in = '0;
      end
      if ((cmd.row_end || cmd.col_cmp) && max_take) begin
         max_in = max_cand[MAX_W-1:0];
      end

      if (cmd.row_adv) begin
         row_in = row_ff + IDX_W'(1);
         if (row_sub_last) begin
            row_sub_in = '0;
            src_in     = src_ff + VTX_W'(1);
         end else begin
            row_sub_in = row_sub_ff + EPR_CW'(1);
         end
      end

      if (cmd.k_clr) begin
         k_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + IDX_W'(1);
      end

      if (run_clr) begin
         row_in     = '0;
         col_in     = '0;
         row_sub_in = '0;
         col_sub_in = '0;
         src_in     = '0;
         dst_in     = '0;
         k_in       = '0;
         row_acc_in = '0;
         total_in   = '0;
         max_in     = '0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      src_out_in    = src_out_ff;
      dst_out_in    = dst_out_ff;
      blk_out_in    = blk_out_ff;
      is_summary_in = is_summary_ff;
      max_out_in    = max_out_ff;
      total_out_in  = total_out_ff;
      last_in       = last_ff;
      if (cmd.load_blk) begin
         rsp_valid_in  = 1'b1;
         src_out_in    = tmbr_pkg::VTX_OUT_W'(src_ff);
         dst_out_in    = tmbr_pkg::VTX_OUT_W'(k_ff);
         blk_out_in    = (IDX_W'(src_ff) == k_ff) ? '0 : $signed(blk_rdata);
         is_summary_in = 1'b0;
         max_out_in    = '0;
         total_out_in  = '0;
         last_in       = 1'b0;
      end else if (cmd.load_sum) begin
         rsp_valid_in  = 1'b1;
         src_out_in    = '0;
         dst_out_in    = '0;
         blk_out_in    = '0;
         is_summary_in = 1'b1;
         max_out_in    = max_ff;
         total_out_in  = total_ff;
         last_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         row_sub_ff   <= '0;
         col_sub_ff   <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         k_ff         <= '0;
         row_acc_ff   <= '0;
         total_ff     <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         row_sub_ff   <= row_sub_in;
         col_sub_ff   <= col_sub_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         k_ff         <= k_in;
         row_acc_ff   <= row_acc_in;
         total_ff     <= total_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flow_ff       <= flow_in;
      src_out_ff    <= src_out_in;
      dst_out_ff    <= dst_out_in;
      blk_out_ff    <= blk_out_in;
      is_summary_ff <= is_summary_in;
      max_out_ff    <= max_out_in;
      total_out_ff  <= total_out_in;
      last_ff       <= last_in;
   end

   assign status.col_last    = (col_ff == side - IDX_W'(1));
   assign status.vertex_last = row_sub_last;
   assign status.row_last    = (row_ff == side - IDX_W'(1));
   assign status.k_last_v    = (k_ff == IDX_W'(eff_v) - IDX_W'(1));
   assign status.k_last_col  = (k_ff == scan_last);
   assign status.rsp_taken   = rsp_valid_ff && rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_src_vertex        = src_out_ff;
   assign rsp_dst_vertex        = dst_out_ff;
   assign rsp_block_flow        = blk_out_ff;
   assign rsp_is_summary        = is_summary_ff;
   assign rsp_max_endpoint_flow = max_out_ff;
   assign rsp_total_flow        = total_out_ff;
   assign rsp_last              = last_ff;

   `TMBR_ASSERT_IMP(a_acc_in_range, cmd.acc, (col_ff < side) && (row_ff < side), "matrix index outside the configured side")
   `TMBR_ASSERT_IMP(a_no_overwrite, cmd.load_blk || cmd.load_sum, !rsp_valid_ff, "result register loaded before it was taken")
   `TMBR_ASSERT_IMP(a_blk_k_range, cmd.blk_rd, k_ff < IDX_W'(eff_v), "block read beyond the vertex count")
   `TMBR_ASSERT_NEXT(a_row_adv_col0, cmd.row_adv, col_ff == '0, "row advanced with the column not wrapped")
endmodule
